@@ rtl/core/sidtb_pkg.sv @@
// Shared types and constants for the self-ID topology builder.
// Used by sidtb_ctrl, sidtb_dp and self_id_topology_builder_top; no dependencies.
package sidtb_pkg;

    localparam int MAX_NODES   = 63;
    localparam int STACK_DEPTH = 16;
    localparam int CHILD_SLOTS = 16;

    localparam int NODE_W   = 6;
    localparam int PORT_W   = 5;
    localparam int CNT_W    = 5;
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int LEVEL_W  = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_AW  = $clog2(CHILD_SLOTS);
    localparam int DIFF_W   = ((LEVEL_W > CNT_W) ? LEVEL_W : CNT_W) + 1;

    localparam int LINK_BIT_POS  = 22;
    localparam int FIELDS_FIRST  = 3;
    localparam int FIELDS_EXT    = 8;
    localparam int PORT_EXT_BASE = 3;
    localparam int LEFT_W        = 4;

    localparam logic [1:0] TYPE_NONE   = 2'h0;
    localparam logic [1:0] TYPE_PARENT = 2'h2;
    localparam logic [1:0] TYPE_CHILD  = 2'h3;

    localparam logic [1:0] FAULT_OK      = 2'd0;
    localparam logic [1:0] FAULT_UNDER   = 2'd1;
    localparam logic [1:0] FAULT_OVER    = 2'd2;
    localparam logic [1:0] FAULT_PACKETS = 2'd3;

    localparam logic [1:0] PKT_FIRST = 2'd0;
    localparam logic [1:0] PKT_EXT1  = 2'd1;
    localparam logic [1:0] PKT_EXT2  = 2'd2;

    typedef struct packed {
        logic [31:0] quadlet;
        logic        scan_start;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_number;
        logic              link_active;
        logic [CNT_W-1:0]  port_total;
        logic [CNT_W-1:0]  port_active;
        logic [CNT_W-1:0]  child_total;
        logic [PORT_W-1:0] parent_port;
        logic              has_parent;
        logic [PORT_W-1:0] child_port;
        logic [NODE_W-1:0] child_node;
        logic              link_present;
        logic [1:0]        fault;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIELD,
        ST_DECIDE,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic field;
        logic decide;
        logic read;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic field_last;
        logic intermediate;
        logic single;
        logic out_free;
        logic rec_last;
    } dp_status_t;

endpackage

@@ rtl/core/sidtb_ctrl.sv @@
// Sequencer for the self-ID topology builder: request intake, field walk, records.
// Depends on sidtb_pkg.
module sidtb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sidtb_pkg::dp_status_t status,
    output sidtb_pkg::ctrl_cmd_t  cmd
);

    sidtb_pkg::state_t state_reg;
    sidtb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sidtb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            sidtb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = sidtb_pkg::ST_FIELD;
                end
            end
            sidtb_pkg::ST_FIELD: begin
                cmd.field = 1'b1;
                if (status.field_last) begin
                    state_next = sidtb_pkg::ST_DECIDE;
                end
            end
            sidtb_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (status.intermediate) begin
                    state_next = sidtb_pkg::ST_IDLE;
                end else if (status.single) begin
                    state_next = sidtb_pkg::ST_LOAD;
                end else begin
                    state_next = sidtb_pkg::ST_READ;
                end
            end
            sidtb_pkg::ST_READ: begin
                cmd.read   = 1'b1;
                state_next = sidtb_pkg::ST_LOAD;
            end
            sidtb_pkg::ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = status.rec_last ? sidtb_pkg::ST_IDLE : sidtb_pkg::ST_READ;
                end
            end
            default: begin
                state_next = sidtb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/sidtb_dp.sv @@
// Datapath for the self-ID topology builder: port counters, child port store,
// node stack and the result register. Depends on sidtb_pkg.
module sidtb_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sidtb_pkg::in_item_t   s_data,
    input  sidtb_pkg::ctrl_cmd_t  cmd,
    output sidtb_pkg::dp_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sidtb_pkg::out_item_t  m_data
);

    logic [sidtb_pkg::NODE_W-1:0]  node_counter_reg;
    logic [sidtb_pkg::LEVEL_W-1:0] stack_level_reg;
    logic [1:0]                    packet_index_reg;
    logic [sidtb_pkg::CNT_W-1:0]   present_count_reg;
    logic [sidtb_pkg::CNT_W-1:0]   connected_count_reg;
    logic [sidtb_pkg::CNT_W-1:0]   child_count_reg;
    logic                          parent_valid_reg;
    logic [sidtb_pkg::PORT_W-1:0]  parent_port_reg;
    logic                          link_flag_reg;

    logic [17:0]                   shift_reg;
    logic                          more_reg;
    logic                          first_reg;
    logic [sidtb_pkg::PORT_W-1:0]  port_reg;
    logic [sidtb_pkg::LEFT_W-1:0]  left_reg;

    logic [sidtb_pkg::NODE_W-1:0]   rec_node_reg;
    logic [1:0]                     rec_fault_reg;
    logic                           single_reg;
    logic [sidtb_pkg::STACK_AW-1:0] base_reg;
    logic [sidtb_pkg::CNT_W-1:0]    k_reg;

    logic [sidtb_pkg::NODE_W-1:0] stack_mem [sidtb_pkg::STACK_DEPTH];
    logic [sidtb_pkg::PORT_W-1:0] ports_mem [sidtb_pkg::CHILD_SLOTS];
    logic [sidtb_pkg::NODE_W-1:0] rd_node_reg;
    logic [sidtb_pkg::PORT_W-1:0] rd_port_reg;

    logic                          m_valid_reg;
    sidtb_pkg::out_item_t          m_data_reg;

    logic [1:0]                     pi_eff;
    logic [1:0]                     ftype;
    logic [sidtb_pkg::DIFF_W-1:0]   level_ext;
    logic [sidtb_pkg::DIFF_W-1:0]   n_ext;
    logic [sidtb_pkg::DIFF_W-1:0]   base_ext;
    logic                           intermediate;
    logic                           limit_hit;
    logic                           under_hit;
    logic                           over_hit;
    logic                           no_child;
    logic                           rec_last;
    logic [sidtb_pkg::CNT_W:0]      rd_sum;
    logic [sidtb_pkg::STACK_AW-1:0] rd_addr;
    logic                           push_we;
    logic [sidtb_pkg::STACK_AW-1:0] push_addr;
    logic                           out_free;

    assign pi_eff    = s_data.scan_start ? sidtb_pkg::PKT_FIRST : packet_index_reg;
    assign ftype     = first_reg ? shift_reg[7:6] : shift_reg[17:16];
    assign level_ext = sidtb_pkg::DIFF_W'(stack_level_reg);
    assign n_ext     = sidtb_pkg::DIFF_W'(child_count_reg);
    assign base_ext  = level_ext - n_ext;

    assign intermediate = more_reg && (packet_index_reg != sidtb_pkg::PKT_EXT2);
    assign limit_hit    = node_counter_reg >= sidtb_pkg::NODE_W'(sidtb_pkg::MAX_NODES);
    assign under_hit    = (n_ext > level_ext)
                       || (child_count_reg > sidtb_pkg::CNT_W'(sidtb_pkg::CHILD_SLOTS));
    assign over_hit     = base_ext >= sidtb_pkg::DIFF_W'(sidtb_pkg::STACK_DEPTH);
    assign no_child     = child_count_reg == '0;
    assign rec_last     = single_reg || (k_reg == child_count_reg - sidtb_pkg::CNT_W'(1));

    assign rd_sum  = (sidtb_pkg::CNT_W + 1)'(base_reg) + (sidtb_pkg::CNT_W + 1)'(k_reg);
    assign rd_addr = rd_sum[sidtb_pkg::STACK_AW-1:0];

    assign out_free = !m_valid_reg || m_ready;

    assign status.field_last   = left_reg == sidtb_pkg::LEFT_W'(1);
    assign status.intermediate = intermediate;
    assign status.single       = limit_hit || under_hit || over_hit || no_child;
    assign status.out_free     = out_free;
    assign status.rec_last     = rec_last;

    always_comb begin
        push_we   = 1'b0;
        push_addr = base_ext[sidtb_pkg::STACK_AW-1:0];
        if (cmd.decide && !intermediate && !limit_hit) begin
            if (under_hit) begin
                push_we   = 1'b1;
                push_addr = '0;
            end else if (!over_hit && no_child) begin
                push_we = 1'b1;
            end
        end else if (cmd.load && !single_reg && rec_last) begin
            push_we   = 1'b1;
            push_addr = base_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_we) begin
            stack_mem[push_addr] <= node_counter_reg;
        end
        if (cmd.field && (ftype == sidtb_pkg::TYPE_CHILD)
            && (child_count_reg < sidtb_pkg::CNT_W'(sidtb_pkg::CHILD_SLOTS))) begin
            ports_mem[child_count_reg[sidtb_pkg::SLOT_AW-1:0]] <= port_reg;
        end
        if (cmd.read) begin
            rd_node_reg <= stack_mem[rd_addr];
            rd_port_reg <= ports_mem[k_reg[sidtb_pkg::SLOT_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_counter_reg    <= '0;
            stack_level_reg     <= '0;
            packet_index_reg    <= '0;
            present_count_reg   <= '0;
            connected_count_reg <= '0;
            child_count_reg     <= '0;
            parent_valid_reg    <= 1'b0;
            parent_port_reg     <= '0;
            link_flag_reg       <= 1'b0;
            left_reg            <= '0;
            single_reg          <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cmd.capture) begin
                if (s_data.scan_start) begin
                    node_counter_reg <= '0;
                    stack_level_reg  <= '0;
                    packet_index_reg <= sidtb_pkg::PKT_FIRST;
                end
                if (pi_eff == sidtb_pkg::PKT_FIRST) begin
                    present_count_reg   <= '0;
                    connected_count_reg <= '0;
                    child_count_reg     <= '0;
                    parent_valid_reg    <= 1'b0;
                    parent_port_reg     <= '0;
                    link_flag_reg       <= s_data.quadlet[sidtb_pkg::LINK_BIT_POS];
                    left_reg            <= sidtb_pkg::LEFT_W'(sidtb_pkg::FIELDS_FIRST);
                end else begin
                    left_reg <= sidtb_pkg::LEFT_W'(sidtb_pkg::FIELDS_EXT);
                end
            end

            if (cmd.field) begin
                left_reg <= left_reg - sidtb_pkg::LEFT_W'(1);
                if (ftype == sidtb_pkg::TYPE_CHILD) begin
                    child_count_reg <= child_count_reg + sidtb_pkg::CNT_W'(1);
                end
                if (ftype == sidtb_pkg::TYPE_PARENT) begin
                    parent_valid_reg <= 1'b1;
                    parent_port_reg  <= port_reg;
                end
                if (ftype[1]) begin
                    connected_count_reg <= connected_count_reg + sidtb_pkg::CNT_W'(1);
                end
                if (ftype != sidtb_pkg::TYPE_NONE) begin
                    present_count_reg <= present_count_reg + sidtb_pkg::CNT_W'(1);
                end
            end

            if (cmd.decide) begin
                if (intermediate) begin
                    packet_index_reg <= packet_index_reg + 2'd1;
                end else begin
                    packet_index_reg <= sidtb_pkg::PKT_FIRST;
                    single_reg       <= limit_hit || under_hit || over_hit || no_child;
                    if (!limit_hit) begin
                        node_counter_reg <= node_counter_reg + sidtb_pkg::NODE_W'(1);
                        if (under_hit) begin
                            stack_level_reg <= sidtb_pkg::LEVEL_W'(1);
                        end else if (!over_hit && no_child) begin
                            stack_level_reg <= sidtb_pkg::LEVEL_W'(base_ext)
                                             + sidtb_pkg::LEVEL_W'(1);
                        end else if (!over_hit) begin
                            node_counter_reg <= node_counter_reg;
                        end
                    end
                end
            end

            if (cmd.load && !single_reg && rec_last) begin
                node_counter_reg <= node_counter_reg + sidtb_pkg::NODE_W'(1);
                stack_level_reg  <= sidtb_pkg::LEVEL_W'(base_reg) + sidtb_pkg::LEVEL_W'(1);
            end

            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            shift_reg <= s_data.quadlet[17:0];
            more_reg  <= s_data.quadlet[0];
            first_reg <= pi_eff == sidtb_pkg::PKT_FIRST;
            if (pi_eff == sidtb_pkg::PKT_FIRST) begin
                port_reg <= '0;
            end else begin
                port_reg <= sidtb_pkg::PORT_W'(sidtb_pkg::PORT_EXT_BASE)
                          + sidtb_pkg::PORT_W'(sidtb_pkg::FIELDS_EXT)
                          * sidtb_pkg::PORT_W'(pi_eff - 2'd1);
            end
        end
        if (cmd.field) begin
            shift_reg <= {shift_reg[15:0], 2'b00};
            port_reg  <= port_reg + sidtb_pkg::PORT_W'(1);
        end
        if (cmd.decide) begin
            rec_node_reg <= node_counter_reg;
            base_reg     <= base_ext[sidtb_pkg::STACK_AW-1:0];
            k_reg        <= '0;
            if (limit_hit) begin
                rec_fault_reg <= sidtb_pkg::FAULT_OVER;
            end else if (under_hit) begin
                rec_fault_reg <= sidtb_pkg::FAULT_UNDER;
            end else if (over_hit) begin
                rec_fault_reg <= sidtb_pkg::FAULT_OVER;
            end else begin
                rec_fault_reg <= more_reg ? sidtb_pkg::FAULT_PACKETS : sidtb_pkg::FAULT_OK;
            end
        end
        if (cmd.load) begin
            k_reg <= k_reg + sidtb_pkg::CNT_W'(1);
            m_data_reg.node_number  <= rec_node_reg;
            m_data_reg.link_active  <= link_flag_reg;
            m_data_reg.port_total   <= present_count_reg;
            m_data_reg.port_active  <= connected_count_reg;
            m_data_reg.child_total  <= child_count_reg;
            m_data_reg.parent_port  <= parent_valid_reg ? parent_port_reg : '0;
            m_data_reg.has_parent   <= parent_valid_reg;
            m_data_reg.child_port   <= single_reg ? '0 : rd_port_reg;
            m_data_reg.child_node   <= single_reg ? '0 : rd_node_reg;
            m_data_reg.link_present <= !single_reg;
            m_data_reg.fault        <= rec_fault_reg;
            m_data_reg.last         <= rec_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/self_id_topology_builder_top.sv @@
// Self-ID topology builder top level: sequencer plus datapath.
// Depends on sidtb_pkg, sidtb_ctrl and sidtb_dp.
// A request is accepted, its port fields are walked one per cycle (3 for packet 0, 8 for
// extended packets) and a decision is made; a packet with more packets to follow ends there.
// The final packet then reads the stack and loads each child record, or loads a single record;
// loads wait for a free result register, which lets the next request enter while a record waits.
// Reset: synchronous, active low; clears node count, stack level and packet state.
module self_id_topology_builder_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sidtb_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sidtb_pkg::out_item_t m_data
);

    sidtb_pkg::ctrl_cmd_t  cmd;
    sidtb_pkg::dp_status_t status;

    sidtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sidtb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.field, cmd.decide, cmd.read, cmd.load}))
        else $error("more than one datapath command");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in progress");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid || m_ready))
        else $error("result register overwritten before transfer");

    a_intermediate_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.decide && status.intermediate) |=> (s_ready && !cmd.load))
        else $error("intermediate packet did not return to intake");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for self_id_topology_builder_top: self-ID scans go in, child-link records come out.
// A local tree-building model predicts every record; depends on sidtb_pkg and the RTL only.
module tb_top;

    localparam logic [1:0] PORT_UNCONNECTED = 2'h1;
    localparam int         QUIET_LIMIT      = 3000;
    localparam int         TAIL_CYCLES      = 100;

    typedef logic [18:0][1:0] port_map_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    sidtb_pkg::in_item_t  s_data;
    logic                 m_valid;
    logic                 m_ready;
    sidtb_pkg::out_item_t m_data;

    // topology model state
    logic [5:0] nodes_seen;
    logic [5:0] node_lifo [sidtb_pkg::STACK_DEPTH];
    int         lifo_level;
    logic [1:0] pkt_idx;
    logic [4:0] present_cnt;
    logic [4:0] connected_cnt;
    logic [4:0] child_cnt;
    logic [4:0] child_port_tbl [sidtb_pkg::CHILD_SLOTS];
    logic       parent_valid;
    logic [4:0] parent_idx;
    logic       link_bit;

    sidtb_pkg::out_item_t pending_records [$];
    sidtb_pkg::out_item_t want;
    int         mismatches;
    int         requests_sent;
    int         quiet_cycles;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         gen_level;
    int         gen_count;

    self_id_topology_builder_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic sidtb_pkg::out_item_t make_record(logic [5:0] node, logic [4:0] cport,
                                                         logic [5:0] cnode, logic present,
                                                         logic [1:0] flt, logic last);
        sidtb_pkg::out_item_t r;
        r.node_number  = node;
        r.link_active  = link_bit;
        r.port_total   = present_cnt;
        r.port_active  = connected_cnt;
        r.child_total  = child_cnt;
        r.parent_port  = parent_valid ? parent_idx : 5'd0;
        r.has_parent   = parent_valid;
        r.child_port   = cport;
        r.child_node   = cnode;
        r.link_present = present;
        r.fault        = flt;
        r.last         = last;
        return r;
    endfunction

    task automatic predict_topology(input sidtb_pkg::in_item_t item);
        logic [31:0] q;
        logic [1:0]  ty;
        logic [1:0]  flt;
        logic        more;
        int          port;
        int          shift;
        int          n;
        int          base;
        q = item.quadlet;
        if (item.scan_start) begin
            nodes_seen = '0;
            lifo_level = 0;
            pkt_idx    = sidtb_pkg::PKT_FIRST;
        end
        if (pkt_idx == sidtb_pkg::PKT_FIRST) begin
            present_cnt   = '0;
            connected_cnt = '0;
            child_cnt     = '0;
            parent_valid  = 1'b0;
            parent_idx    = '0;
            link_bit      = q[sidtb_pkg::LINK_BIT_POS];
            port          = 0;
            shift         = 6;
        end else begin
            port  = sidtb_pkg::PORT_EXT_BASE + sidtb_pkg::FIELDS_EXT * (pkt_idx - 1);
            shift = 16;
        end
        while (shift >= 2) begin
            ty = q[shift +: 2];
            if (ty == sidtb_pkg::TYPE_CHILD) begin
                if (child_cnt < sidtb_pkg::CHILD_SLOTS) child_port_tbl[child_cnt] = 5'(port);
                if (child_cnt < 31) child_cnt++;
            end
            if (ty == sidtb_pkg::TYPE_PARENT) begin
                parent_valid = 1'b1;
                parent_idx   = 5'(port);
            end
            if (ty >= sidtb_pkg::TYPE_PARENT) connected_cnt++;
            if (ty != sidtb_pkg::TYPE_NONE) present_cnt++;
            port++;
            shift -= 2;
        end
        more = q[0];
        if (more && pkt_idx != sidtb_pkg::PKT_EXT2) begin
            pkt_idx++;
            return;
        end
        flt     = more ? sidtb_pkg::FAULT_PACKETS : sidtb_pkg::FAULT_OK;
        pkt_idx = sidtb_pkg::PKT_FIRST;
        n       = child_cnt;
        if (nodes_seen >= sidtb_pkg::MAX_NODES) begin
            pending_records.push_back(make_record(nodes_seen, '0, '0, 1'b0,
                                                  sidtb_pkg::FAULT_OVER, 1'b1));
        end else if (n > lifo_level || n > sidtb_pkg::CHILD_SLOTS) begin
            pending_records.push_back(make_record(nodes_seen, '0, '0, 1'b0,
                                                  sidtb_pkg::FAULT_UNDER, 1'b1));
            node_lifo[0] = nodes_seen;
            lifo_level   = 1;
            nodes_seen++;
        end else begin
            base = lifo_level - n;
            if (base >= sidtb_pkg::STACK_DEPTH) begin
                pending_records.push_back(make_record(nodes_seen, '0, '0, 1'b0,
                                                      sidtb_pkg::FAULT_OVER, 1'b1));
                lifo_level = base;
                nodes_seen++;
            end else begin
                if (n == 0)
                    pending_records.push_back(make_record(nodes_seen, '0, '0, 1'b0, flt, 1'b1));
                for (int k = 0; k < n; k++)
                    pending_records.push_back(make_record(nodes_seen, child_port_tbl[k],
                                                         node_lifo[base + k], 1'b1, flt,
                                                         k == n - 1));
                node_lifo[base] = nodes_seen;
                lifo_level      = base + 1;
                nodes_seen++;
            end
        end
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_topology(s_data);
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $error("record from node %0d with nothing expected", m_data.node_number);
                mismatches++;
            end else begin
                want = pending_records.pop_front();
                check_field("node_number", want.node_number, m_data.node_number);
                check_field("link_active", want.link_active, m_data.link_active);
                check_field("port_total", want.port_total, m_data.port_total);
                check_field("port_active", want.port_active, m_data.port_active);
                check_field("child_total", want.child_total, m_data.child_total);
                check_field("parent_port", want.parent_port, m_data.parent_port);
                check_field("has_parent", want.has_parent, m_data.has_parent);
                check_field("child_port", want.child_port, m_data.child_port);
                check_field("child_node", want.child_node, m_data.child_node);
                check_field("link_present", want.link_present, m_data.link_present);
                check_field("fault", want.fault, m_data.fault);
                check_field("last", want.last, m_data.last);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_request(input sidtb_pkg::in_item_t item);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // hold the sender until every expected record is back
    task automatic drain_records;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_records.size() != 0);
    endtask

    task automatic send_node(input port_map_t pm, input int np, input bit scan,
                             input bit overrun);
        sidtb_pkg::in_item_t item;
        for (int k = 0; k < np; k++) begin
            item.quadlet    = $urandom;
            item.scan_start = scan && k == 0;
            if (k == 0) begin
                for (int j = 0; j < sidtb_pkg::FIELDS_FIRST; j++)
                    item.quadlet[7 - 2 * j -: 2] = pm[j];
            end else begin
                for (int j = 0; j < sidtb_pkg::FIELDS_EXT; j++)
                    item.quadlet[17 - 2 * j -: 2] =
                        pm[sidtb_pkg::PORT_EXT_BASE + sidtb_pkg::FIELDS_EXT * (k - 1) + j];
            end
            item.quadlet[0] = (k < np - 1) || (overrun && k == 2);
            send_request(item);
        end
    endtask

    function automatic port_map_t random_ports(int children, int np, int parents);
        port_map_t pm;
        int        span;
        int        p;
        int        left;
        span = sidtb_pkg::FIELDS_FIRST + sidtb_pkg::FIELDS_EXT * (np - 1);
        pm   = '0;
        for (int j = 0; j < span; j++)
            pm[j] = $urandom_range(0, 1) ? PORT_UNCONNECTED : sidtb_pkg::TYPE_NONE;
        left = children;
        while (left > 0) begin
            p = $urandom_range(0, span - 1);
            if (pm[p] != sidtb_pkg::TYPE_CHILD) begin
                pm[p] = sidtb_pkg::TYPE_CHILD;
                left--;
            end
        end
        left = (parents > span - children) ? span - children : parents;
        while (left > 0) begin
            p = $urandom_range(0, span - 1);
            if (pm[p] != sidtb_pkg::TYPE_CHILD && pm[p] != sidtb_pkg::TYPE_PARENT) begin
                pm[p] = sidtb_pkg::TYPE_PARENT;
                left--;
            end
        end
        return pm;
    endfunction

    // one node of a scan; children drawn from what the stack can give, or one more when broken
    task automatic gen_node(input bit scan, input bit root, input bit broken);
        int c;
        int np;
        int par;
        if (scan) begin
            gen_level = 0;
            gen_count = 0;
        end
        c = (gen_level > sidtb_pkg::CHILD_SLOTS) ? sidtb_pkg::CHILD_SLOTS : gen_level;
        if (!root) c = $urandom_range(0, c);
        if (broken) c = gen_level + 1;
        if (c > 11) np = 3;
        else if (c > 3) np = $urandom_range(2, 3);
        else np = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        par = root ? 0 : (($urandom_range(0, 9) == 0) ? 2 : 1);
        send_node(random_ports(c, np, par), np, scan, np == 3 && $urandom_range(0, 9) == 0);
        if (gen_count < sidtb_pkg::MAX_NODES) begin
            if (c > gen_level || c > sidtb_pkg::CHILD_SLOTS) gen_level = 1;
            else if (gen_level - c < sidtb_pkg::STACK_DEPTH) gen_level = gen_level - c + 1;
            gen_count++;
        end
    endtask

    task automatic test_field_extremes;
        port_map_t pm;
        send_request('{quadlet: 32'h0000_0000, scan_start: 1'b1});
        send_request('{quadlet: 32'h0000_0000, scan_start: 1'b0});
        // three child-heavy packets, the last still chained: underflow with overrun
        send_request('{quadlet: 32'hFFFF_FFFF, scan_start: 1'b1});
        send_request('{quadlet: 32'hFFFF_FFFF, scan_start: 1'b0});
        send_request('{quadlet: 32'hFFFF_FFFF, scan_start: 1'b0});
        pm = '0;
        pm[18] = sidtb_pkg::TYPE_PARENT;
        send_node(pm, 3, 1'b0, 1'b1);
        drain_records;
    endtask

    task automatic test_small_tree;
        port_map_t pm;
        pm = '0; pm[1] = sidtb_pkg::TYPE_PARENT;
        send_node(pm, 1, 1'b1, 1'b0);
        pm = '0; pm[0] = sidtb_pkg::TYPE_PARENT; pm[2] = PORT_UNCONNECTED;
        send_node(pm, 1, 1'b0, 1'b0);
        pm = '0; pm[2] = sidtb_pkg::TYPE_PARENT;
        send_node(pm, 1, 1'b0, 1'b0);
        pm = '0;
        pm[0] = sidtb_pkg::TYPE_CHILD; pm[2] = sidtb_pkg::TYPE_CHILD;
        pm[18] = sidtb_pkg::TYPE_CHILD;
        pm[1] = sidtb_pkg::TYPE_PARENT; pm[5] = sidtb_pkg::TYPE_PARENT;
        pm[9] = PORT_UNCONNECTED;
        send_node(pm, 3, 1'b0, 1'b0);
        pm = '0; pm[10] = sidtb_pkg::TYPE_CHILD;
        send_node(pm, 2, 1'b0, 1'b0);
        drain_records;
    endtask

    task automatic test_restart_mid_node;
        send_request('{quadlet: 32'h0040_00C5, scan_start: 1'b1});
        send_request('{quadlet: 32'h0000_0080, scan_start: 1'b1});
        drain_records;
    endtask

    task automatic test_stack_overflow;
        port_map_t pm;
        pm = '0; pm[0] = sidtb_pkg::TYPE_PARENT;
        for (int i = 0; i < sidtb_pkg::STACK_DEPTH + 1; i++) send_node(pm, 1, i == 0, 1'b0);
        pm = '0;
        for (int j = 0; j < sidtb_pkg::CHILD_SLOTS; j++) pm[j + 3] = sidtb_pkg::TYPE_CHILD;
        send_node(pm, 3, 1'b0, 1'b0);
        drain_records;
    endtask

    task automatic test_node_limit;
        port_map_t pm;
        pm = '0; pm[2] = sidtb_pkg::TYPE_PARENT;
        send_node(pm, 1, 1'b1, 1'b0);
        pm = '0; pm[0] = sidtb_pkg::TYPE_CHILD; pm[1] = sidtb_pkg::TYPE_PARENT;
        for (int i = 1; i < sidtb_pkg::MAX_NODES + 2; i++) send_node(pm, 1, 1'b0, 1'b0);
        pm = '0;
        send_node(pm, 1, 1'b1, 1'b0);
        drain_records;
    endtask

    task automatic test_random_scans(input int idle_pct, input int stall_pct, input int items);
        int goal;
        int nodes;
        sidtb_pkg::in_item_t noise;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        goal = requests_sent + items;
        while (requests_sent < goal) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    noise.quadlet    = $urandom;
                    noise.scan_start = ($urandom_range(0, 3) == 0);
                    send_request(noise);
                end
            end else begin
                nodes = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66)
                                                    : $urandom_range(1, 10);
                for (int i = 0; i < nodes; i++)
                    gen_node(i == 0, i == nodes - 1 && $urandom_range(0, 3) != 0,
                             $urandom_range(0, 19) == 0);
            end
        end
        drain_records;
    endtask

    initial begin
        aclk               = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        m_ready            = 1'b0;
        nodes_seen         = '0;
        lifo_level         = 0;
        pkt_idx            = sidtb_pkg::PKT_FIRST;
        present_cnt        = '0;
        connected_cnt      = '0;
        child_cnt          = '0;
        parent_valid       = 1'b0;
        parent_idx         = '0;
        link_bit           = 1'b0;
        mismatches         = 0;
        requests_sent      = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        gen_level          = 0;
        gen_count          = 0;
        for (int i = 0; i < sidtb_pkg::STACK_DEPTH; i++) node_lifo[i] = '0;
        for (int i = 0; i < sidtb_pkg::CHILD_SLOTS; i++) child_port_tbl[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes;
        test_small_tree;
        test_restart_mid_node;
        test_stack_overflow;
        test_node_limit;
        test_random_scans(0, 0, 70);
        test_random_scans(56, 0, 70);
        test_random_scans(0, 56, 70);
        test_random_scans(7, 7, 70);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
